/* hdl/hpd_pkg.sv */
package hpd_pkg;

  localparam int unsigned CoefW   = 48;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FracW   = 16;
  localparam int unsigned QuotW   = 32;

  typedef logic signed [CoefW-1:0] coef_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_X_FROM_X = 3'd0,
    REG_X_FROM_Y = 3'd1,
    REG_X_OFFSET = 3'd2,
    REG_W_FROM_X = 3'd3,
    REG_W_FROM_Y = 3'd4,
    REG_W_OFFSET = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    coef_t xx;
    coef_t xy;
    coef_t xo;
    coef_t wx;
    coef_t wy;
    coef_t wo;
  } coef_set_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic ovf;
    logic zero;
  } stage_ctrl_t;

  localparam coef_t CoefOne = 48'sh0001_0000_0000;
  localparam coef_t CoefZero = 48'sh0;

  localparam logic [QuotW-1:0] SatPos = 32'h7fff_ffff;
  localparam logic [QuotW-1:0] SatNeg = 32'h8000_0000;

endpackage

/* hdl/hpd_front.sv */
module hpd_front #(
  parameter int unsigned COORD_BITS = 12,
  localparam int unsigned ProdW = hpd_pkg::CoefW + COORD_BITS + 1,
  localparam int unsigned DenW  = ProdW + 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      in_valid_i,
  input  logic [COORD_BITS-1:0]     x_i,
  input  logic [COORD_BITS-1:0]     y_i,
  input  hpd_pkg::coef_set_t        coef_i,
  output hpd_pkg::stage_ctrl_t      ctrl_o,
  output logic [DenW-1:0]           rem_o,
  output logic [hpd_pkg::QuotW-1:0] dq_o,
  output logic [DenW-1:0]           dmag_o
);
  import hpd_pkg::*;

  localparam int unsigned XdW  = DenW + COORD_BITS + 1;
  localparam int unsigned TW   = XdW + 1;
  localparam int unsigned CmpW = TW + FracW;

  logic [4:0] valid_q;

  // products
  logic [COORD_BITS-1:0]   x1_q;
  logic signed [ProdW-1:0] pxx_d, pxy_d, pwx_d, pwy_d;
  logic signed [ProdW-1:0] pxx_q, pxy_q, pwx_q, pwy_q;
  // numerator and denominator
  logic [COORD_BITS-1:0]   x2_q;
  logic signed [DenW-1:0]  num_d, den_d, num_q, den_q;
  // x times denominator
  logic signed [XdW-1:0]   xd_d, xd_q;
  logic signed [DenW-1:0]  num3_q;
  logic [DenW-1:0]         dmag_d, dmag3_q, dmag4_q, dmag5_q;
  logic                    dneg3_q, dneg4_q, zero_d, zero3_q, zero4_q, zero5_q;
  // difference and magnitude
  logic signed [TW-1:0]    t_d, t_q;
  logic [TW-1:0]           tmag_d, tmag_q;
  logic                    neg_d, neg5_q;
  // overflow check and divider seed
  logic                    ovf_d;
  logic [DenW-1:0]         rem_d, rem_q;
  logic [QuotW-1:0]        dq_d, dq_q;
  logic [DenW-1:0]         dmag6_q;
  stage_ctrl_t             ctrl_q;

  always_comb begin
    pxx_d  = ProdW'(coef_i.xx) * ProdW'($signed({1'b0, x_i}));
    pxy_d  = ProdW'(coef_i.xy) * ProdW'($signed({1'b0, y_i}));
    pwx_d  = ProdW'(coef_i.wx) * ProdW'($signed({1'b0, x_i}));
    pwy_d  = ProdW'(coef_i.wy) * ProdW'($signed({1'b0, y_i}));
    num_d  = DenW'(pxx_q) + DenW'(pxy_q) + DenW'(coef_i.xo);
    den_d  = DenW'(pwx_q) + DenW'(pwy_q) + DenW'(coef_i.wo);
    xd_d   = XdW'(den_q) * XdW'($signed({1'b0, x2_q}));
    dmag_d = den_q[DenW-1] ? DenW'(-den_q) : DenW'(den_q);
    zero_d = (den_q == '0);
    t_d    = TW'(xd_q) - TW'(num3_q);
    tmag_d = t_q[TW-1] ? TW'(-t_q) : TW'(t_q);
    neg_d  = t_q[TW-1] ^ dneg4_q;
    ovf_d  = ({{FracW{1'b0}}, tmag_q} >= CmpW'({dmag5_q, {FracW{1'b0}}}));
    rem_d  = DenW'(tmag_q >> FracW);
    dq_d   = {tmag_q[FracW-1:0], {(QuotW - FracW){1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ctrl_q  <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[3:0], in_valid_i};
      ctrl_q  <= '{valid: valid_q[4], neg: neg5_q, ovf: ovf_d, zero: zero5_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= x_i;
      pxx_q   <= pxx_d;
      pxy_q   <= pxy_d;
      pwx_q   <= pwx_d;
      pwy_q   <= pwy_d;
      x2_q    <= x1_q;
      num_q   <= num_d;
      den_q   <= den_d;
      xd_q    <= xd_d;
      num3_q  <= num_q;
      dmag3_q <= dmag_d;
      dneg3_q <= den_q[DenW-1];
      zero3_q <= zero_d;
      t_q     <= t_d;
      dmag4_q <= dmag3_q;
      dneg4_q <= dneg3_q;
      zero4_q <= zero3_q;
      tmag_q  <= tmag_d;
      neg5_q  <= neg_d;
      dmag5_q <= dmag4_q;
      zero5_q <= zero4_q;
      rem_q   <= rem_d;
      dq_q    <= dq_d;
      dmag6_q <= dmag5_q;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign dq_o   = dq_q;
  assign dmag_o = dmag6_q;

endmodule

/* hdl/hpd_div.sv */
module hpd_div #(
  parameter int unsigned DenW = 63
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  hpd_pkg::stage_ctrl_t      ctrl_i,
  input  logic [DenW-1:0]           rem_i,
  input  logic [hpd_pkg::QuotW-1:0] dq_i,
  input  logic [DenW-1:0]           dmag_i,
  output hpd_pkg::stage_ctrl_t      ctrl_o,
  output logic [hpd_pkg::QuotW-1:0] quot_o
);
  import hpd_pkg::*;

  stage_ctrl_t      ctrl_q [QuotW];
  logic [DenW-1:0]  rem_q  [QuotW];
  logic [DenW-1:0]  dmag_q [QuotW];
  logic [QuotW-1:0] dq_q   [QuotW];

  // one quotient bit per stage, remainder stays below the divisor
  for (genvar k = 0; k < QuotW; k++) begin : g_step
    stage_ctrl_t      ctrl_in;
    logic [DenW-1:0]  rem_in, dmag_in, rem_d;
    logic [QuotW-1:0] dq_in, dq_d;
    logic [DenW:0]    trial;
    logic [DenW+1:0]  diff;
    logic             fits;

    if (k == 0) begin : g_first
      assign ctrl_in = ctrl_i;
      assign rem_in  = rem_i;
      assign dmag_in = dmag_i;
      assign dq_in   = dq_i;
    end else begin : g_next
      assign ctrl_in = ctrl_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign dmag_in = dmag_q[k-1];
      assign dq_in   = dq_q[k-1];
    end

    assign trial = {rem_in, dq_in[QuotW-1]};
    assign diff  = {1'b0, trial} - {2'b00, dmag_in};
    assign fits  = !diff[DenW+1];
    assign rem_d = fits ? diff[DenW-1:0] : trial[DenW-1:0];
    assign dq_d  = {dq_in[QuotW-2:0], fits};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[k] <= '0;
      end else if (en_i) begin
        ctrl_q[k] <= ctrl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        dmag_q[k] <= dmag_in;
        dq_q[k]   <= dq_d;
      end
    end
  end

  assign ctrl_o = ctrl_q[QuotW-1];
  assign quot_o = dq_q[QuotW-1];

endmodule

/* hdl/hpd_obuf.sv */
module hpd_obuf #(
  parameter int unsigned DataW = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [DataW-1:0] data_o
);

  logic [DataW-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             pop;

  assign pop      = valid_o && ready_i;
  assign wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
  assign rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign space_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output buffer count out of range");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != 2'd2)
    else $error("push into full output buffer");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push_i |=> count_q == $past(count_q) - 2'd1)
    else $error("pop did not drain output buffer");

endmodule

/* hdl/homography_pixel_disparity.sv */
// Projects each pixel (x, y) through the x row of a homography,
// xp = (a*x + b*y + c) / (g*x + h*y + i), and returns x - xp in signed Q16.16,
// saturated to 32 bits, with a zero-denominator flag in tuser (disparity 0).
// One word is accepted per clock while the output buffer has space. Path: six
// front stages (products, sums, x times denominator, difference, magnitude,
// range check), a 32-stage restoring divider that retires one quotient bit per
// stage, a saturation stage and a two-word output buffer. Write coefficients
// through the cfg port while no word is in flight; the block does not check.
module homography_pixel_disparity #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pixel_x, pixel_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // disparity
  output logic [31:0]                     m_axis_tdata,
  // zero_denominator
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hpd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [hpd_pkg::CoefW-1:0]       cfg_data_i
);
  import hpd_pkg::*;

  localparam int unsigned DenW = CoefW + COORD_BITS + 3;

  coef_set_t        coef_q, coef_d;
  logic             en;
  stage_ctrl_t      front_ctrl, div_ctrl;
  logic [DenW-1:0]  front_rem, front_dmag;
  logic [QuotW-1:0] front_dq, quot;
  logic [QuotW-1:0] res_d, res_q;
  logic             res_valid_q, zero_q;

  // coefficient registers
  always_comb begin
    coef_d = coef_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_X_FROM_X: coef_d.xx = cfg_data_i;
        REG_X_FROM_Y: coef_d.xy = cfg_data_i;
        REG_X_OFFSET: coef_d.xo = cfg_data_i;
        REG_W_FROM_X: coef_d.wx = cfg_data_i;
        REG_W_FROM_Y: coef_d.wy = cfg_data_i;
        REG_W_OFFSET: coef_d.wo = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.xx <= CoefOne;
      coef_q.xy <= CoefZero;
      coef_q.xo <= CoefZero;
      coef_q.wx <= CoefZero;
      coef_q.wy <= CoefZero;
      coef_q.wo <= CoefOne;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = en;

  hpd_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_valid_i(s_axis_tvalid),
    .x_i       (s_axis_tdata[COORD_BITS-1:0]),
    .y_i       (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .coef_i    (coef_q),
    .ctrl_o    (front_ctrl),
    .rem_o     (front_rem),
    .dq_o      (front_dq),
    .dmag_o    (front_dmag)
  );

  hpd_div #(
    .DenW(DenW)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .ctrl_i(front_ctrl),
    .rem_i (front_rem),
    .dq_i  (front_dq),
    .dmag_i(front_dmag),
    .ctrl_o(div_ctrl),
    .quot_o(quot)
  );

  // sign and saturation
  always_comb begin
    priority if (div_ctrl.zero) begin
      res_d = '0;
    end else if (div_ctrl.ovf) begin
      res_d = div_ctrl.neg ? SatNeg : SatPos;
    end else if (div_ctrl.neg) begin
      res_d = (quot > SatNeg) ? SatNeg : QuotW'(-quot);
    end else begin
      res_d = quot[QuotW-1] ? SatPos : quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en) begin
      res_valid_q <= div_ctrl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      zero_q <= div_ctrl.zero;
    end
  end

  hpd_obuf #(
    .DataW(QuotW + 1)
  ) u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (en && res_valid_q),
    .data_i ({zero_q, res_q}),
    .space_o(en),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o ({m_axis_tuser, m_axis_tdata})
  );

  a_zero_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("zero denominator with nonzero disparity");

  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.valid && div_ctrl.ovf && !div_ctrl.zero |->
      res_d == SatPos || res_d == SatNeg)
    else $error("out of range quotient not saturated");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && res_valid_q |=> $stable(res_q) && res_valid_q)
    else $error("result stage changed while stalled");

endmodule

/* test/tb_homography_pixel_disparity.sv */
`timescale 1ns / 1ps

module tb_homography_pixel_disparity;
  import hpd_pkg::*;

  localparam int unsigned CoordBits  = 12;
  localparam int unsigned NumCoef    = 6;
  localparam int unsigned Latency    = 40;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned PhaseItems = 180;
  localparam int unsigned FloodItems = 120;

  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

  localparam coef_t CoefMax = 48'sh7fff_ffff_ffff;
  localparam coef_t CoefMin = 48'sh8000_0000_0000;
  localparam coef_t CoefLsb = 48'sd1;

  localparam logic [CoordBits-1:0] CoordMax = '1;

  typedef struct packed {
    logic [QuotW-1:0] disparity;
    logic             zero_den;
  } disparity_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CoefW-1:0]     cfg_data_i = '0;

  coef_t       coef_model [NumCoef];
  disparity_t  expected_q [$];
  disparity_t  want_word;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  logic [CoordBits-1:0] zero_x = '0;
  logic [CoordBits-1:0] zero_y = '0;
  int unsigned zero_bias_pct = 0;

  homography_pixel_disparity #(
    .COORD_BITS(CoordBits)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic disparity_t project_disparity(input logic [CoordBits-1:0] px,
                                                   input logic [CoordBits-1:0] py);
    logic signed [127:0] xs, ys, ca, cb, cc, cg, ch, ci, num, den, t;
    logic [127:0] tmag, dmag, q;
    logic neg;
    disparity_t r;
    xs = {116'd0, px};
    ys = {116'd0, py};
    ca = 128'(coef_model[REG_X_FROM_X]);
    cb = 128'(coef_model[REG_X_FROM_Y]);
    cc = 128'(coef_model[REG_X_OFFSET]);
    cg = 128'(coef_model[REG_W_FROM_X]);
    ch = 128'(coef_model[REG_W_FROM_Y]);
    ci = 128'(coef_model[REG_W_OFFSET]);
    num = ca * xs + cb * ys + cc;
    den = cg * xs + ch * ys + ci;
    r.zero_den = 1'b0;
    if (den == 0) begin
      r.disparity = '0;
      r.zero_den = 1'b1;
    end else begin
      t = den * xs - num;
      neg = t[127] ^ den[127];
      tmag = t[127] ? -t : t;
      tmag = tmag << FracW;
      dmag = den[127] ? -den : den;
      q = tmag / dmag;
      if (neg) begin
        if (q > 128'h8000_0000) r.disparity = SatNeg;
        else r.disparity = 32'(-q);
      end else begin
        if (q > 128'h7fff_ffff) r.disparity = SatPos;
        else r.disparity = q[QuotW-1:0];
      end
    end
    return r;
  endfunction

  function automatic coef_t rand_coef();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[CoefW-1:0];
  endfunction

  // uniform in [-2^bits, 2^bits)
  function automatic coef_t rand_span(input int unsigned bits);
    coef_t v;
    v = rand_coef();
    return v >>> (CoefW - 1 - bits);
  endfunction

  function automatic coef_t pick_extreme();
    case ($urandom_range(6))
      0: return CoefMax;
      1: return CoefMin;
      2: return CoefZero;
      3: return CoefOne;
      4: return -CoefOne;
      5: return CoefLsb;
      default: return -CoefLsb;
    endcase
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected word: disparity %h zero_den %b", m_axis_tdata, m_axis_tuser);
      end else begin
        want_word = expected_q.pop_front();
        if (m_axis_tdata !== want_word.disparity || m_axis_tuser !== want_word.zero_den) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("mismatch: disparity exp %h got %h, zero_den exp %b got %b",
                     want_word.disparity, m_axis_tdata, want_word.zero_den, m_axis_tuser);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_homography_pixel_disparity: FAIL");
    $finish;
  end

  task automatic send_pixel(input logic [CoordBits-1:0] px, input logic [CoordBits-1:0] py);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q = {expected_q, project_disparity(px, py)};
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high so back-to-back writes need no gap
  task automatic write_coef(input logic [CfgIdxW-1:0] idx, input coef_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= REG_W_OFFSET) coef_model[idx] = val;
  endtask

  task automatic set_coefs(input coef_t a, input coef_t b, input coef_t c,
                           input coef_t g, input coef_t h, input coef_t i);
    write_coef(REG_X_FROM_X, a);
    write_coef(REG_X_FROM_Y, b);
    write_coef(REG_X_OFFSET, c);
    write_coef(REG_W_FROM_X, g);
    write_coef(REG_W_FROM_Y, h);
    write_coef(REG_W_OFFSET, i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 81; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 81; end
      default: begin sender_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  task automatic pick_coefs(input int unsigned kind);
    coef_t g, h, zx, zy;
    zero_bias_pct = 0;
    case (kind)
      0: set_coefs(rand_coef(), rand_coef(), rand_coef(),
                   rand_coef(), rand_coef(), rand_coef());
      1: set_coefs(CoefOne + rand_span(28), rand_span(28), rand_span(40),
                   rand_span(20), rand_span(20), CoefOne + rand_span(28));
      2: set_coefs(pick_extreme(), pick_extreme(), pick_extreme(),
                   pick_extreme(), pick_extreme(), pick_extreme());
      default: begin
        // denominator vanishes at a chosen pixel
        zero_x = CoordBits'($urandom_range(CoordMax));
        zero_y = CoordBits'($urandom_range(CoordMax));
        zx = CoefW'(zero_x);
        zy = CoefW'(zero_y);
        g = rand_span(33);
        h = rand_span(33);
        set_coefs(rand_span(40), rand_span(40), rand_span(40), g, h, -(g * zx + h * zy));
        zero_bias_pct = 25;
      end
    endcase
  endtask

  task automatic next_pixel(output logic [CoordBits-1:0] px, output logic [CoordBits-1:0] py);
    if ($urandom_range(99) < zero_bias_pct) begin
      px = zero_x;
      py = zero_y;
    end else if ($urandom_range(9) == 0) begin
      px = $urandom_range(1) ? CoordMax : '0;
      py = $urandom_range(1) ? CoordMax : '0;
    end else begin
      px = CoordBits'($urandom_range(CoordMax));
      py = CoordBits'($urandom_range(CoordMax));
    end
  endtask

  task automatic test_identity();
    send_pixel('0, '0);
    send_pixel(CoordMax, CoordMax);
    send_pixel(CoordMax, '0);
    send_pixel('0, CoordMax);
    send_pixel(12'd2730, 12'd1365);
    wait_drained();
  endtask

  task automatic test_saturation();
    set_coefs(CoefMax, CoefZero, CoefZero, CoefZero, CoefZero, CoefOne);
    send_pixel('0, '0);
    send_pixel(CoordMax, CoordMax);
    send_pixel(12'd1, CoordMax);
    wait_drained();
    set_coefs(CoefMin, CoefZero, CoefMax, CoefZero, CoefMin, CoefLsb);
    send_pixel('0, '0);
    send_pixel(CoordMax, '0);
    send_pixel(CoordMax, CoordMax);
    wait_drained();
  endtask

  task automatic test_zero_denominator();
    set_coefs(CoefOne, CoefZero, CoefZero, CoefZero, CoefZero, CoefZero);
    send_pixel('0, '0);
    send_pixel(CoordMax, CoordMax);
    wait_drained();
    set_coefs(CoefOne, CoefZero, CoefZero, CoefOne, CoefZero, -(CoefOne * 48'sd100));
    send_pixel(12'd100, CoordMax);
    send_pixel(12'd101, 12'd5);
    send_pixel(12'd99, '0);
    wait_drained();
  endtask

  task automatic test_unknown_index();
    write_coef(RegUnusedLo, CoefMax);
    write_coef(RegUnusedHi, CoefMin);
    cfg_valid_i <= 1'b0;
    send_pixel(12'd100, 12'd7);
    send_pixel(CoordMax, CoordMax);
    send_pixel('0, '0);
    wait_drained();
  endtask

  task automatic test_random();
    logic [CoordBits-1:0] px, py;
    for (int unsigned p = 0; p < 8; p++) begin
      pick_coefs((p / 2) % 4);
      set_idling(p % 4);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        next_pixel(px, py);
        send_pixel(px, py);
      end
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    logic [CoordBits-1:0] px, py;
    set_idling(0);
    pick_coefs(1);
    hold_requests++;
    for (int unsigned n = 0; n < FloodItems; n++) begin
      next_pixel(px, py);
      send_pixel(px, py);
    end
    wait_drained();
  endtask

  initial begin
    coef_model[REG_X_FROM_X] = CoefOne;
    coef_model[REG_X_FROM_Y] = CoefZero;
    coef_model[REG_X_OFFSET] = CoefZero;
    coef_model[REG_W_FROM_X] = CoefZero;
    coef_model[REG_W_FROM_Y] = CoefZero;
    coef_model[REG_W_OFFSET] = CoefOne;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity();
    test_saturation();
    test_zero_denominator();
    test_unknown_index();
    test_random();
    test_backpressure();
    wait_drained();
    repeat (Latency + 20) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_homography_pixel_disparity: PASS");
    end else begin
      $display("tb_homography_pixel_disparity: FAIL");
    end
    $finish;
  end

endmodule
